// ----- rtl/sitd_pkg.sv -----
// ---------------------------------------------------------------------------
// sitd_pkg
// Shared constants, types and helpers for the signed integer to decimal
// text converter.
// ---------------------------------------------------------------------------
package sitd_pkg;

  localparam int VALUE_WIDTH_DEFAULT = 32;

  localparam logic [6:0] CHAR_ZERO  = 7'd48;
  localparam logic [6:0] CHAR_MINUS = 7'd45;

  // Number of decimal digits kept for a magnitude of up to 2^width.
  // The factor 30103/100000 is log10(2), rounded to five places, and one more digit
  // covers the fraction.
  function automatic int digit_count(input int width);
    return (width * 30103) / 100000 + 1;
  endfunction

  // Status of the binary to BCD converter.
  typedef struct packed {
    logic busy;  // shifting the magnitude in
    logic done;  // BCD word valid for this one cycle
  } dabble_status_t;

endpackage

// ----- rtl/signed_int_to_decimal_text.sv -----
// Flow: an accepted item passes through the one-bit-per-cycle BCD converter; the
// sequencer then sends a minus sign for a negative item, skips leading zero digits
// and sends the remaining digits. A new item is taken only once the sequencer has
// moved the final character of the last one into its output register.
// Reset: synchronous, active high; clears converter and sequencer control and drops
// text_valid. No clearing pass is needed.
// ---------------------------------------------------------------------------
// signed_int_to_decimal_text
// Converts a two's complement integer to its decimal ASCII text, one
// character per output item, most significant first, with last on the end.
// ---------------------------------------------------------------------------
module signed_int_to_decimal_text #(
  parameter int VALUE_WIDTH = sitd_pkg::VALUE_WIDTH_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   value_valid,
  output logic                   value_stall,
  input  logic [VALUE_WIDTH-1:0] value,
  output logic                   text_valid,
  input  logic                   text_stall,
  output logic [6:0]             character,
  output logic                   last
);

  localparam int BcdWidth = 4 * sitd_pkg::digit_count(VALUE_WIDTH);

  sitd_pkg::dabble_status_t dab_status;
  logic [BcdWidth-1:0]      bcd;
  logic [VALUE_WIDTH-1:0]   magnitude;
  logic                     accept;
  logic                     emit_idle;
  logic                     negative;

  // One item at a time: the next is taken once the sequencer has moved the
  // final character of the current item into its output register, while that
  // character may still be waiting to go out.
  assign value_stall = dab_status.busy || dab_status.done || !emit_idle;
  assign accept      = value_valid && !value_stall;

  // The most negative value negates to itself, which read unsigned is
  // exactly its magnitude.
  assign magnitude = value[VALUE_WIDTH-1] ? (~value + VALUE_WIDTH'(1)) : value;

  always_ff @(posedge clk) begin
    if (accept) begin
      negative <= value[VALUE_WIDTH-1];
    end
  end

  sitd_dabble #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_dabble (
    .clk      (clk),
    .rst      (rst),
    .start    (accept),
    .magnitude(magnitude),
    .status   (dab_status),
    .bcd      (bcd)
  );

  sitd_emit #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_emit (
    .clk       (clk),
    .rst       (rst),
    .load      (dab_status.done),
    .negative  (negative),
    .bcd       (bcd),
    .idle      (emit_idle),
    .text_valid(text_valid),
    .text_stall(text_stall),
    .character (character),
    .last      (last)
  );

`ifndef NO_ASSERTIONS
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    accept |=> dab_status.busy)
    else $error("accepted item did not start the converter");

  a_done_needs_idle: assert property (@(posedge clk) disable iff (rst)
    dab_status.done |-> emit_idle)
    else $error("converter finished while the sequencer was busy");

  a_no_busy_done: assert property (@(posedge clk) disable iff (rst)
    !(dab_status.busy && dab_status.done))
    else $error("converter busy and done together");

  a_char_code: assert property (@(posedge clk) disable iff (rst)
    text_valid |-> (character == sitd_pkg::CHAR_MINUS ||
                    (character >= sitd_pkg::CHAR_ZERO && character <= 7'd57)))
    else $error("character is neither a digit nor a minus sign");

  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    (text_valid && character == sitd_pkg::CHAR_MINUS) |-> !last)
    else $error("minus sign flagged as the final character");
`endif

endmodule

// ----- rtl/sitd_dabble.sv -----
// ---------------------------------------------------------------------------
// sitd_dabble
// Bit-serial binary to BCD converter (shift and add three). One bit of the
// magnitude enters the BCD register per cycle, most significant bit first.
// ---------------------------------------------------------------------------
module sitd_dabble #(
  parameter int VALUE_WIDTH = sitd_pkg::VALUE_WIDTH_DEFAULT
) (
  input  logic                                            clk,
  input  logic                                            rst,
  input  logic                                            start,
  input  logic [VALUE_WIDTH-1:0]                          magnitude,
  output sitd_pkg::dabble_status_t                        status,
  output logic [4*sitd_pkg::digit_count(VALUE_WIDTH)-1:0] bcd
);

  localparam int NumDigits = sitd_pkg::digit_count(VALUE_WIDTH);
  localparam int BcdWidth  = 4 * NumDigits;
  localparam int CntWidth  = $clog2(VALUE_WIDTH + 1);

  logic [VALUE_WIDTH-1:0] mag;
  logic [BcdWidth-1:0]    digits;
  logic [BcdWidth-1:0]    digits_adj;
  logic [CntWidth-1:0]    count;
  logic                   busy;
  logic                   done;

  // Every digit of five or more gets three added before the shift, so that
  // it carries correctly into the next digit.
  always_comb begin
    for (int d = 0; d < NumDigits; d++) begin
      if (digits[4*d +: 4] >= 4'd5) begin
        digits_adj[4*d +: 4] = digits[4*d +: 4] + 4'd3;
      end else begin
        digits_adj[4*d +: 4] = digits[4*d +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CntWidth'(VALUE_WIDTH);
      end else if (busy) begin
        count <= count - CntWidth'(1);
        if (count == CntWidth'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mag    <= magnitude;
      digits <= '0;
    end else if (busy) begin
      mag    <= {mag[VALUE_WIDTH-2:0], 1'b0};
      digits <= {digits_adj[BcdWidth-2:0], mag[VALUE_WIDTH-1]};
    end
  end

  assign status.busy = busy;
  assign status.done = done;
  assign bcd         = digits;

endmodule

// ----- rtl/sitd_emit.sv -----
// ---------------------------------------------------------------------------
// sitd_emit
// Text sequencer: sends the optional minus sign, skips leading zero digits
// and shifts the remaining BCD digits out one per item through an output
// register.
// ---------------------------------------------------------------------------
module sitd_emit #(
  parameter int VALUE_WIDTH = sitd_pkg::VALUE_WIDTH_DEFAULT
) (
  input  logic                                            clk,
  input  logic                                            rst,
  input  logic                                            load,
  input  logic                                            negative,
  input  logic [4*sitd_pkg::digit_count(VALUE_WIDTH)-1:0] bcd,
  output logic                                            idle,
  output logic                                            text_valid,
  input  logic                                            text_stall,
  output logic [6:0]                                      character,
  output logic                                            last
);

  localparam int NumDigits = sitd_pkg::digit_count(VALUE_WIDTH);
  localparam int BcdWidth  = 4 * NumDigits;
  localparam int RemWidth  = $clog2(NumDigits + 1);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SIGN  = 4'b0010,
    ST_SKIP  = 4'b0100,
    ST_DIGIT = 4'b1000
  } emit_state_t;

  emit_state_t         state, state_next;
  logic [BcdWidth-1:0] digits, digits_next;
  logic [RemWidth-1:0] remaining, remaining_next;
  logic                valid, valid_next;
  logic [6:0]          char_reg, char_next;
  logic                last_reg, last_next;
  logic                slot_free;
  logic [3:0]          top_digit;

  assign slot_free = !valid || !text_stall;
  assign top_digit = digits[BcdWidth-1 -: 4];

  always_comb begin
    state_next     = state;
    digits_next    = digits;
    remaining_next = remaining;
    valid_next     = valid && text_stall;
    char_next      = char_reg;
    last_next      = last_reg;
    unique case (state)
      ST_IDLE: begin
        if (load) begin
          digits_next    = bcd;
          remaining_next = RemWidth'(NumDigits);
          state_next     = negative ? ST_SIGN : ST_SKIP;
        end
      end
      ST_SIGN: begin
        if (slot_free) begin
          valid_next = 1'b1;
          char_next  = sitd_pkg::CHAR_MINUS;
          last_next  = 1'b0;
          state_next = ST_SKIP;
        end
      end
      ST_SKIP: begin
        // The final digit is always sent, so zero still gives one '0'.
        if (top_digit == 4'd0 && remaining != RemWidth'(1)) begin
          digits_next    = {digits[BcdWidth-5:0], 4'd0};
          remaining_next = remaining - RemWidth'(1);
        end else begin
          state_next = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        if (slot_free) begin
          valid_next     = 1'b1;
          char_next      = sitd_pkg::CHAR_ZERO + {3'b000, top_digit};
          last_next      = (remaining == RemWidth'(1));
          digits_next    = {digits[BcdWidth-5:0], 4'd0};
          remaining_next = remaining - RemWidth'(1);
          if (remaining == RemWidth'(1)) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      valid     <= 1'b0;
      remaining <= '0;
    end else begin
      state     <= state_next;
      valid     <= valid_next;
      remaining <= remaining_next;
    end
  end

  always_ff @(posedge clk) begin
    digits   <= digits_next;
    char_reg <= char_next;
    last_reg <= last_next;
  end

  assign idle       = (state == ST_IDLE);
  assign text_valid = valid;
  assign character  = char_reg;
  assign last       = last_reg;

endmodule
